// File: rtl/core/wsl_pkg.sv
// Shared types and constants for the WENO slope limiter.
package wsl_pkg;

    localparam int NUM_CAND = 5;
    localparam int DATA_W = 32;

    localparam logic [31:0] ONE_Q30 = 32'd1073741824;
    localparam logic [31:0] POLY_C1 = 32'd747109561;
    localparam logic [31:0] POLY_C2 = 32'd241699284;
    localparam logic [31:0] POLY_C3 = 32'd84932978;

    typedef enum logic [1:0] {
        REG_CELL_WIDTH     = 2'd0,
        REG_INV_CELL_WIDTH = 2'd1,
        REG_WEIGHT_DEGREE  = 2'd2,
        REG_WEIGHT_EPSILON = 2'd3
    } wsl_reg_t;

    typedef struct packed {
        logic vld;
        logic last;
        logic clip;
    } wsl_side_t;

endpackage

// File: rtl/core/weno_slope_limiter.sv
// Pipelined Hermite WENO slope limiter for one solution component per transfer.
//
// Channel   Direction  Content
// s_        in         means and slopes of a cell and both neighbors, last flag
// m_        out        limited slope, cell done flag, saturation flag
// cfg_      in         register writes: h, 1/h, weight degree, epsilon
//
// One transfer is accepted per cycle unless the result side stalls. The pipeline
// has one squaring stage per log2 fraction bit and one stage per quotient bit
// of the weighted mean divider. Reset clears all valid bits and loads the register
// defaults. A stall on the result side freezes the whole pipeline in place.
module weno_slope_limiter #(
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_mean_left,
    input  logic [31:0] s_mean_center,
    input  logic [31:0] s_mean_right,
    input  logic [31:0] s_slope_left,
    input  logic [31:0] s_slope_center,
    input  logic [31:0] s_slope_right,
    input  logic        s_last_component,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_limited_slope,
    output logic        m_cell_done,
    output logic        m_saturated,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data
);

    localparam int NC  = wsl_pkg::NUM_CAND;
    localparam int LW  = FRAC_BITS + 7;
    localparam int EW  = LW + 17;
    localparam int AW  = EW + 1;
    localparam int QW  = AW - FRAC_BITS;
    localparam int DVW = 33;
    localparam int RW  = 66;
    localparam int QB  = 32;

    logic [30:0] cw_reg;
    logic [30:0] icw_reg;
    logic [15:0] deg_reg;
    logic [16:0] eps_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cw_reg  <= 31'd1 << FRAC_BITS;
            icw_reg <= 31'd1 << FRAC_BITS;
            deg_reg <= 16'd8192;
            eps_reg <= 17'd1;
        end else if (cfg_wr_en) begin
            unique case (wsl_pkg::wsl_reg_t'(cfg_index))
                wsl_pkg::REG_CELL_WIDTH:     cw_reg  <= cfg_data;
                wsl_pkg::REG_INV_CELL_WIDTH: icw_reg <= cfg_data;
                wsl_pkg::REG_WEIGHT_DEGREE:  deg_reg <= cfg_data[15:0];
                wsl_pkg::REG_WEIGHT_EPSILON: eps_reg <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    logic adv;
    logic out_vld_reg;
    assign adv = !out_vld_reg || m_ready;
    assign s_ready = adv;

    // Stage 1: candidate magnitudes and signs.
    wsl_pkg::wsl_side_t p1_side_reg;
    logic [NC-1:0]       p1_neg_reg;
    logic [NC-1:0][32:0] p1_mag_reg;
    logic [NC-1:0][32:0] p1_v;

    always_comb begin
        p1_v[0] = {s_slope_center[31], s_slope_center};
        p1_v[1] = {s_slope_left[31], s_slope_left};
        p1_v[2] = {s_slope_right[31], s_slope_right};
        p1_v[3] = {s_mean_center[31], s_mean_center} - {s_mean_left[31], s_mean_left};
        p1_v[4] = {s_mean_right[31], s_mean_right} - {s_mean_center[31], s_mean_center};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_side_reg <= '0;
        end else if (adv) begin
            p1_side_reg <= '{vld: s_valid, last: s_last_component, clip: 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < NC; i++) begin
                p1_neg_reg[i] <= p1_v[i][32];
                p1_mag_reg[i] <= p1_v[i][32] ? 33'(-p1_v[i]) : p1_v[i];
            end
        end
    end

    // Stage 2: scaling products.
    wsl_pkg::wsl_side_t p2_side_reg;
    logic [NC-1:0]       p2_neg_reg;
    logic [NC-1:0][64:0] p2_prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_side_reg <= '0;
        end else if (adv) begin
            p2_side_reg <= p1_side_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p2_neg_reg <= p1_neg_reg;
            for (int i = 0; i < NC; i++) begin
                if (i < 3) begin
                    p2_prod_reg[i] <= 65'(p1_mag_reg[i]) * 65'({icw_reg, 1'b0});
                end else begin
                    p2_prod_reg[i] <= 65'(p1_mag_reg[i]) * 65'(icw_reg);
                end
            end
        end
    end

    // Stage 3: saturation and log2 argument.
    wsl_pkg::wsl_side_t p3_side_reg;
    logic [NC-1:0][31:0] p3_m_reg;
    logic [NC-1:0][32:0] p3_x_reg;
    logic [NC-1:0][31:0] p3_m;
    logic [NC-1:0][32:0] p3_x;
    logic                p3_clip;

    always_comb begin
        logic [64:0] sh;
        logic [64:0] lim;
        logic [31:0] mabs;
        p3_clip = 1'b0;
        for (int i = 0; i < NC; i++) begin
            sh  = p2_prod_reg[i] >> FRAC_BITS;
            lim = p2_neg_reg[i] ? 65'h0_8000_0000 : 65'h0_7FFF_FFFF;
            if (sh > lim) begin
                p3_clip = 1'b1;
                mabs = lim[31:0];
            end else begin
                mabs = sh[31:0];
            end
            p3_m[i] = p2_neg_reg[i] ? 32'(-mabs) : mabs;
            p3_x[i] = 33'(eps_reg) + 33'(mabs);
            if (p3_x[i] == '0) begin
                p3_x[i] = 33'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_side_reg <= '0;
        end else if (adv) begin
            p3_side_reg <= '{vld: p2_side_reg.vld, last: p2_side_reg.last, clip: p3_clip};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p3_m_reg <= p3_m;
            p3_x_reg <= p3_x;
        end
    end

    // Stage 4 and squaring stages: log2 mantissa normalization and fraction bits.
    wsl_pkg::wsl_side_t           sq_side_reg [FRAC_BITS+1];
    logic [NC-1:0][31:0]          sq_m_reg    [FRAC_BITS+1];
    logic [NC-1:0][30:0]          sq_mant_reg [FRAC_BITS+1];
    logic [NC-1:0][5:0]           sq_msb_reg  [FRAC_BITS+1];
    logic [NC-1:0][FRAC_BITS-1:0] sq_frac_reg [FRAC_BITS+1];
    logic [NC-1:0][30:0]          p4_mant;
    logic [NC-1:0][5:0]           p4_msb;

    always_comb begin
        logic [32:0] nx;
        for (int i = 0; i < NC; i++) begin
            p4_msb[i] = '0;
            for (int b = 0; b < 33; b++) begin
                if (p3_x_reg[i][b]) begin
                    p4_msb[i] = 6'(b);
                end
            end
            if (p4_msb[i] <= 6'd30) begin
                nx = p3_x_reg[i] << (6'd30 - p4_msb[i]);
            end else begin
                nx = p3_x_reg[i] >> (p4_msb[i] - 6'd30);
            end
            p4_mant[i] = nx[30:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_side_reg[0] <= '0;
        end else if (adv) begin
            sq_side_reg[0] <= p3_side_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_m_reg[0]    <= p3_m_reg;
            sq_mant_reg[0] <= p4_mant;
            sq_msb_reg[0]  <= p4_msb;
            sq_frac_reg[0] <= '0;
        end
    end

    for (genvar j = 0; j < FRAC_BITS; j++) begin : g_sq
        logic [NC-1:0][30:0]          mant_next;
        logic [NC-1:0][FRAC_BITS-1:0] frac_next;

        always_comb begin
            logic [61:0] sq;
            for (int i = 0; i < NC; i++) begin
                sq = 62'(sq_mant_reg[j][i]) * 62'(sq_mant_reg[j][i]);
                mant_next[i] = sq[61] ? sq[61:31] : sq[60:30];
                frac_next[i] = {sq_frac_reg[j][i][FRAC_BITS-2:0], sq[61]};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_side_reg[j+1] <= '0;
            end else if (adv) begin
                sq_side_reg[j+1] <= sq_side_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_m_reg[j+1]    <= sq_m_reg[j];
                sq_mant_reg[j+1] <= mant_next;
                sq_msb_reg[j+1]  <= sq_msb_reg[j];
                sq_frac_reg[j+1] <= frac_next;
            end
        end
    end

    // Weight exponent e = floor(-(degree * log2) / 4096).
    wsl_pkg::wsl_side_t  ex_side_reg;
    logic [NC-1:0][31:0] ex_m_reg;
    logic [NC-1:0][EW-1:0] ex_e_reg;
    logic [NC-1:0][EW-1:0] ex_e;

    always_comb begin
        logic signed [LW-1:0] lg;
        logic signed [EW-1:0] dl;
        logic signed [EW-1:0] ng;
        for (int i = 0; i < NC; i++) begin
            lg = ((LW'($signed({1'b0, sq_msb_reg[FRAC_BITS][i]})) - LW'(FRAC_BITS))
                  <<< FRAC_BITS) + LW'($signed({1'b0, sq_frac_reg[FRAC_BITS][i]}));
            dl = $signed({1'b0, deg_reg}) * lg;
            ng = -dl;
            ex_e[i] = ng >>> 12;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_side_reg <= '0;
        end else if (adv) begin
            ex_side_reg <= sq_side_reg[FRAC_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ex_m_reg <= sq_m_reg[FRAC_BITS];
            ex_e_reg <= ex_e;
        end
    end

    // Largest exponent.
    wsl_pkg::wsl_side_t    mx_side_reg;
    logic [NC-1:0][31:0]   mx_m_reg;
    logic [NC-1:0][EW-1:0] mx_e_reg;
    logic [EW-1:0]         mx_max_reg;
    logic [EW-1:0]         mx_max;

    always_comb begin
        mx_max = ex_e_reg[0];
        for (int i = 1; i < NC; i++) begin
            if ($signed(ex_e_reg[i]) > $signed(mx_max)) begin
                mx_max = ex_e_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mx_side_reg <= '0;
        end else if (adv) begin
            mx_side_reg <= ex_side_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mx_m_reg   <= ex_m_reg;
            mx_e_reg   <= ex_e_reg;
            mx_max_reg <= mx_max;
        end
    end

    // Split the exponent difference into shift and fraction.
    wsl_pkg::wsl_side_t  ad_side_reg;
    logic [NC-1:0][31:0] ad_m_reg;
    logic [NC-1:0][29:0] ad_fq_reg;
    logic [NC-1:0][5:0]  ad_s_reg;
    logic [NC-1:0]       ad_zero_reg;
    logic [NC-1:0][29:0] ad_fq;
    logic [NC-1:0][5:0]  ad_s;
    logic [NC-1:0]       ad_zero;
    logic [NC-1:0]       ad_top;

    always_comb begin
        logic [AW-1:0]        a;
        logic [QW-1:0]        q;
        logic [FRAC_BITS-1:0] r;
        for (int i = 0; i < NC; i++) begin
            a = AW'($signed(mx_max_reg)) - AW'($signed(mx_e_reg[i]));
            r = a[FRAC_BITS-1:0];
            q = a[AW-1:FRAC_BITS] + QW'(r != '0);
            ad_top[i]  = (a == '0);
            ad_fq[i]   = {FRAC_BITS'(-r), (30 - FRAC_BITS)'(0)};
            ad_zero[i] = (q >= QW'(38));
            ad_s[i]    = ad_zero[i] ? 6'd0 : 6'(q) + 6'd2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ad_side_reg <= '0;
        end else if (adv) begin
            ad_side_reg <= mx_side_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ad_m_reg    <= mx_m_reg;
            ad_fq_reg   <= ad_fq;
            ad_s_reg    <= ad_s;
            ad_zero_reg <= ad_zero;
        end
    end

    // Three Horner steps of the 2^f polynomial.
    wsl_pkg::wsl_side_t  py_side_reg [3];
    logic [NC-1:0][31:0] py_m_reg    [3];
    logic [NC-1:0][29:0] py_fq_reg   [3];
    logic [NC-1:0][5:0]  py_s_reg    [3];
    logic [NC-1:0]       py_zero_reg [3];
    logic [NC-1:0][31:0] py_acc_reg  [3];
    logic [NC-1:0][31:0] py_acc0;
    logic [NC-1:0][31:0] py_acc1;
    logic [NC-1:0][31:0] py_acc2;

    always_comb begin
        logic [61:0] p;
        for (int i = 0; i < NC; i++) begin
            p = 62'(wsl_pkg::POLY_C3) * 62'(ad_fq_reg[i]);
            py_acc0[i] = wsl_pkg::POLY_C2 + p[61:30];
            p = 62'(py_acc_reg[0][i]) * 62'(py_fq_reg[0][i]);
            py_acc1[i] = wsl_pkg::POLY_C1 + p[61:30];
            p = 62'(py_acc_reg[1][i]) * 62'(py_fq_reg[1][i]);
            py_acc2[i] = wsl_pkg::ONE_Q30 + p[61:30];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                py_side_reg[k] <= '0;
            end
        end else if (adv) begin
            py_side_reg[0] <= ad_side_reg;
            py_side_reg[1] <= py_side_reg[0];
            py_side_reg[2] <= py_side_reg[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            py_m_reg[0]    <= ad_m_reg;
            py_fq_reg[0]   <= ad_fq_reg;
            py_s_reg[0]    <= ad_s_reg;
            py_zero_reg[0] <= ad_zero_reg;
            py_acc_reg[0]  <= py_acc0;
            for (int k = 1; k < 3; k++) begin
                py_m_reg[k]    <= py_m_reg[k-1];
                py_fq_reg[k]   <= py_fq_reg[k-1];
                py_s_reg[k]    <= py_s_reg[k-1];
                py_zero_reg[k] <= py_zero_reg[k-1];
            end
            py_acc_reg[1] <= py_acc1;
            py_acc_reg[2] <= py_acc2;
        end
    end

    // Weights in Q1.28.
    wsl_pkg::wsl_side_t  wt_side_reg;
    logic [NC-1:0][31:0] wt_m_reg;
    logic [NC-1:0][29:0] wt_w_reg;
    logic [NC-1:0][29:0] wt_w;

    always_comb begin
        logic [31:0] sh;
        for (int i = 0; i < NC; i++) begin
            sh = py_acc_reg[2][i] >> py_s_reg[2][i];
            wt_w[i] = py_zero_reg[2][i] ? 30'd0 : sh[29:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wt_side_reg <= '0;
        end else if (adv) begin
            wt_side_reg <= py_side_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            wt_m_reg <= py_m_reg[2];
            wt_w_reg <= wt_w;
        end
    end

    // Weighted candidates and weight sum.
    wsl_pkg::wsl_side_t  wm_side_reg;
    logic [NC-1:0][62:0] wm_prod_reg;
    logic [DVW-1:0]      wm_den_reg;
    logic [DVW-1:0]      wm_den;

    always_comb begin
        wm_den = '0;
        for (int i = 0; i < NC; i++) begin
            wm_den = wm_den + DVW'(wt_w_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wm_side_reg <= '0;
        end else if (adv) begin
            wm_side_reg <= wt_side_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < NC; i++) begin
                wm_prod_reg[i] <= 63'($signed({1'b0, wt_w_reg[i]}) * $signed(wt_m_reg[i]));
            end
            wm_den_reg <= wm_den;
        end
    end

    // Numerator sum.
    wsl_pkg::wsl_side_t sm_side_reg;
    logic [RW-1:0]      sm_num_reg;
    logic [DVW-1:0]     sm_den_reg;
    logic [RW-1:0]      sm_num;

    always_comb begin
        sm_num = '0;
        for (int i = 0; i < NC; i++) begin
            sm_num = sm_num + RW'($signed(wm_prod_reg[i]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sm_side_reg <= '0;
        end else if (adv) begin
            sm_side_reg <= wm_side_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sm_num_reg <= sm_num;
            sm_den_reg <= wm_den_reg;
        end
    end

    // Restoring divider on magnitudes, one quotient bit per stage.
    wsl_pkg::wsl_side_t dv_side_reg [QB+1];
    logic [RW-1:0]      dv_rem_reg  [QB+1];
    logic [DVW-1:0]     dv_den_reg  [QB+1];
    logic [QB-1:0]      dv_q_reg    [QB+1];
    logic               dv_neg_reg  [QB+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_side_reg[0] <= '0;
        end else if (adv) begin
            dv_side_reg[0] <= sm_side_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_neg_reg[0] <= sm_num_reg[RW-1];
            dv_rem_reg[0] <= sm_num_reg[RW-1] ? RW'(-sm_num_reg) : sm_num_reg;
            dv_den_reg[0] <= sm_den_reg;
            dv_q_reg[0]   <= '0;
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int B = QB - 1 - j;
        logic [RW-1:0] trial;
        logic          ge;
        logic [QB-1:0] q_next;

        always_comb begin
            trial = RW'(dv_den_reg[j]) << B;
            ge = dv_rem_reg[j] >= trial;
            q_next = dv_q_reg[j];
            q_next[B] = ge;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_side_reg[j+1] <= '0;
            end else if (adv) begin
                dv_side_reg[j+1] <= dv_side_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_rem_reg[j+1] <= ge ? dv_rem_reg[j] - trial : dv_rem_reg[j];
                dv_den_reg[j+1] <= dv_den_reg[j];
                dv_q_reg[j+1]   <= q_next;
                dv_neg_reg[j+1] <= dv_neg_reg[j];
            end
        end
    end

    // Half-width scaling product.
    wsl_pkg::wsl_side_t fm_side_reg;
    logic [62:0]        fm_prod_reg;
    logic               fm_neg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fm_side_reg <= '0;
        end else if (adv) begin
            fm_side_reg <= dv_side_reg[QB];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            fm_prod_reg <= 63'(dv_q_reg[QB]) * 63'(cw_reg);
            fm_neg_reg  <= dv_neg_reg[QB];
        end
    end

    // Final saturation and output register.
    logic [31:0] out_slope_reg;
    logic        out_done_reg;
    logic        out_sat_reg;
    logic [31:0] fo_slope;
    logic        fo_clip;

    always_comb begin
        logic [62:0] sh;
        logic [62:0] lim;
        logic [31:0] mag;
        sh  = fm_prod_reg >> (FRAC_BITS + 1);
        lim = fm_neg_reg ? 63'h8000_0000 : 63'h7FFF_FFFF;
        fo_clip = sh > lim;
        mag = fo_clip ? lim[31:0] : sh[31:0];
        fo_slope = fm_neg_reg ? 32'(-mag) : mag;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= fm_side_reg.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_slope_reg <= fo_slope;
            out_done_reg  <= fm_side_reg.last;
            out_sat_reg   <= fm_side_reg.clip || fo_clip;
        end
    end

    assign m_valid         = out_vld_reg;
    assign m_limited_slope = out_slope_reg;
    assign m_cell_done     = out_done_reg;
    assign m_saturated     = out_sat_reg;

    a_div_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        dv_side_reg[0].vld |-> dv_den_reg[0] != '0)
        else $error("weighted mean divisor is zero");

    a_top_weight_present: assert property (@(posedge aclk) disable iff (!aresetn)
        ad_side_reg.vld |-> !(&ad_zero_reg))
        else $error("largest exponent lane missing");

    a_max_lane_exists: assert property (@(posedge aclk) disable iff (!aresetn)
        mx_side_reg.vld |-> ad_top != '0)
        else $error("no candidate carries the largest exponent");

    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(fm_side_reg) && $stable(dv_side_reg[0]))
        else $error("pipeline moved during a stall");

endmodule

// File: bench/wsl_checker.sv
// Checker for the WENO slope limiter: predicts each limited slope and compares the results.
module wsl_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] s_mean_left,
    input  logic [31:0] s_mean_center,
    input  logic [31:0] s_mean_right,
    input  logic [31:0] s_slope_left,
    input  logic [31:0] s_slope_center,
    input  logic [31:0] s_slope_right,
    input  logic        s_last_component,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_limited_slope,
    input  logic        m_cell_done,
    input  logic        m_saturated,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data,
    output int          errors,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = 16;
    localparam longint unsigned Q30 = 64'd1 << 30;
    localparam longint unsigned K1 = 64'd6958 * Q30 / 64'd10000;
    localparam longint unsigned K2 = 64'd2251 * Q30 / 64'd10000;
    localparam longint unsigned K3 = 64'd791 * Q30 / 64'd10000;

    typedef struct packed {
        logic [31:0] slope;
        logic        done;
        logic        clip;
    } slope_result_t;

    logic [30:0] h_reg, inv_h_reg;
    logic [15:0] degree_reg;
    logic [16:0] eps_reg;
    slope_result_t pending_slopes[$];

    function automatic longint clamp32(longint v, inout bit clip);
        if (v > 64'sd2147483647) begin
            clip = 1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            clip = 1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint mul_shift(longint v, longint unsigned k, int sh);
        longint unsigned mag;
        mag = (v < 0) ? longint'(-v) : longint'(v);
        mag = (mag * k) >> sh;
        return (v < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint log2_q(longint unsigned x);
        int msb;
        longint unsigned t, mant, frac;
        msb = 0;
        frac = 0;
        if (x == 0) x = 1;
        t = x;
        while (t > 1) begin
            t = t >> 1;
            msb++;
        end
        mant = (msb <= 30) ? (x << (30 - msb)) : (x >> (msb - 30));
        for (int i = 0; i < FB; i++) begin
            mant = (mant * mant) >> 30;
            frac = frac << 1;
            if (mant >= (Q30 << 1)) begin
                frac = frac | 1;
                mant = mant >> 1;
            end
        end
        return longint'(msb - FB) * (64'sd1 <<< FB) + longint'(frac);
    endfunction

    function automatic longint unsigned pow2_frac(longint unsigned f);
        longint unsigned acc;
        acc = K3;
        acc = K2 + ((acc * f) >> 30);
        acc = K1 + ((acc * f) >> 30);
        return Q30 + ((acc * f) >> 30);
    endfunction

    function automatic slope_result_t limit_slope(logic [31:0] ml, logic [31:0] mc,
            logic [31:0] mr, logic [31:0] sl, logic [31:0] sc, logic [31:0] sr,
            logic last);
        longint cand[5], ex[5];
        longint emax, num, mean;
        longint unsigned den, k2, mag, a, q, r, frac, pw, s, w;
        bit clip;
        slope_result_t res;
        clip = 0;
        num = 0;
        den = 0;
        k2 = longint'(inv_h_reg) * 2;
        cand[0] = clamp32(mul_shift(longint'(signed'(sc)), k2, FB), clip);
        cand[1] = clamp32(mul_shift(longint'(signed'(sl)), k2, FB), clip);
        cand[2] = clamp32(mul_shift(longint'(signed'(sr)), k2, FB), clip);
        cand[3] = clamp32(mul_shift(longint'(signed'(mc)) - longint'(signed'(ml)),
                                    longint'(inv_h_reg), FB), clip);
        cand[4] = clamp32(mul_shift(longint'(signed'(mr)) - longint'(signed'(mc)),
                                    longint'(inv_h_reg), FB), clip);
        for (int i = 0; i < 5; i++) begin
            longint p;
            mag = (cand[i] < 0) ? longint'(-cand[i]) : longint'(cand[i]);
            p = -(longint'(degree_reg) * log2_q(longint'(eps_reg) + mag));
            ex[i] = (p >= 0) ? (p >>> 12) : -longint'((longint'(-p) + 4095) >> 12);
        end
        emax = ex[0];
        for (int i = 1; i < 5; i++)
            if (ex[i] > emax) emax = ex[i];
        for (int i = 0; i < 5; i++) begin
            a = emax - ex[i];
            q = a >> FB;
            r = a & ((64'd1 << FB) - 1);
            frac = 0;
            if (r != 0) begin
                q++;
                frac = (64'd1 << FB) - r;
            end
            pw = pow2_frac(frac << (30 - FB));
            s = q + 2;
            w = (s >= 40) ? 0 : (pw >> s);
            num += longint'(w) * cand[i];
            den += w;
        end
        mean = num / longint'(den);
        res.slope = 32'(clamp32(mul_shift(mean, longint'(h_reg), FB + 1), clip));
        res.done = last;
        res.clip = clip;
        return res;
    endfunction

    assign outstanding = pending_slopes.size();

    always @(posedge aclk) begin
        if (!aresetn) begin
            h_reg <= 31'd65536;
            inv_h_reg <= 31'd65536;
            degree_reg <= 16'd8192;
            eps_reg <= 17'd1;
            errors <= 0;
            pending_slopes.delete();
        end else begin
            if (cfg_wr_en) begin
                case (wsl_pkg::wsl_reg_t'(cfg_index))
                    wsl_pkg::REG_CELL_WIDTH:     h_reg <= cfg_data;
                    wsl_pkg::REG_INV_CELL_WIDTH: inv_h_reg <= cfg_data;
                    wsl_pkg::REG_WEIGHT_DEGREE:  degree_reg <= cfg_data[15:0];
                    wsl_pkg::REG_WEIGHT_EPSILON: eps_reg <= cfg_data[16:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                pending_slopes.push_back(limit_slope(s_mean_left, s_mean_center,
                    s_mean_right, s_slope_left, s_slope_center, s_slope_right,
                    s_last_component));
            if (m_valid && m_ready) begin
                if (pending_slopes.size() == 0) begin
                    if (errors < 10)
                        $display("Unexpected result transfer: slope %h", m_limited_slope);
                    errors <= errors + 1;
                end else begin
                    slope_result_t exp_r;
                    exp_r = pending_slopes.pop_front();
                    if (exp_r.slope !== m_limited_slope || exp_r.done !== m_cell_done ||
                            exp_r.clip !== m_saturated) begin
                        if (errors < 10)
                            $display("Mismatch: expected slope %h done %b sat %b, got %h %b %b",
                                     exp_r.slope, exp_r.done, exp_r.clip,
                                     m_limited_slope, m_cell_done, m_saturated);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

// File: bench/testbench.sv
// Top of the slope limiter testbench: clock, reset, stimulus phases and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk, aresetn;
    logic        s_valid, s_ready, s_last_component;
    logic [31:0] s_mean_left, s_mean_center, s_mean_right;
    logic [31:0] s_slope_left, s_slope_center, s_slope_right;
    logic        m_valid, m_ready, m_cell_done, m_saturated;
    logic [31:0] m_limited_slope;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [30:0] cfg_data;
    int          errors, outstanding;
    int          cycles;
    int          idle_pct;
    bit          sender_idles, receiver_stalls;

    weno_slope_limiter uut (.*);
    wsl_checker checker_i (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > 800000) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial m_ready = 1;
    always @(negedge aclk)
        m_ready <= !(receiver_stalls && $urandom_range(99) < idle_pct);

    task automatic write_settings(logic [30:0] h, logic [30:0] inv_h, logic [30:0] deg,
                                  logic [30:0] eps);
        wsl_pkg::wsl_reg_t idx[4] = '{wsl_pkg::REG_CELL_WIDTH, wsl_pkg::REG_INV_CELL_WIDTH,
                                      wsl_pkg::REG_WEIGHT_DEGREE,
                                      wsl_pkg::REG_WEIGHT_EPSILON};
        logic [30:0] val[4];
        val = '{h, inv_h, deg, eps};
        for (int i = 0; i < 4; i++) begin
            @(negedge aclk);
            cfg_wr_en <= 1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
        end
        @(negedge aclk);
        cfg_wr_en <= 0;
    endtask

    task automatic send_component(logic [31:0] ml, logic [31:0] mc, logic [31:0] mr,
            logic [31:0] sl, logic [31:0] sc, logic [31:0] sr, logic last);
        logic rdy;
        @(negedge aclk);
        while (sender_idles && $urandom_range(99) < idle_pct) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_valid <= 1;
        s_mean_left <= ml;
        s_mean_center <= mc;
        s_mean_right <= mr;
        s_slope_left <= sl;
        s_slope_center <= sc;
        s_slope_right <= sr;
        s_last_component <= last;
        rdy = 1'b0;
        while (!rdy) begin
            #1;
            rdy = s_ready;
            @(posedge aclk);
            if (!rdy) @(negedge aclk);
        end
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] corners[5] = '{32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h1, 32'hFFFFFFFF};
        case ($urandom_range(9))
            0: return corners[$urandom_range(4)];
            1, 2: return $urandom;
            default: return 32'($urandom_range(32'h1FFFFF)) - 32'h100000;
        endcase
    endfunction

    function automatic logic [31:0] near(logic [31:0] v);
        return ($urandom_range(3) == 0) ? pick_value()
                                        : v + 32'($urandom_range(16'hFFFF)) - 32'h8000;
    endfunction

    task automatic send_random();
        logic [31:0] mc;
        mc = pick_value();
        send_component(near(mc), mc, near(mc), pick_value(), pick_value(), pick_value(),
                       1'($urandom));
    endtask

    task automatic settle();
        while (outstanding != 0) @(posedge aclk);
        repeat (70) @(posedge aclk);
    endtask

    initial begin
        logic [30:0] ph_h[8] = '{31'd65536, 31'd1, 31'h7FFFFFFF, 31'd0, 31'd65536, 31'd0,
                                 31'd32768, 31'd0};
        logic [30:0] ph_inv[8] = '{31'd65536, 31'd1, 31'h7FFFFFFF, 31'd65536, 31'd0,
                                   31'd0, 31'd131072, 31'd0};
        logic [30:0] ph_deg[8] = '{31'd8192, 31'd0, 31'd65535, 31'd8192, 31'd4096, 31'd0,
                                   31'd12288, 31'd0};
        logic [30:0] ph_eps[8] = '{31'd1, 31'd65536, 31'd1, 31'd0, 31'd256, 31'd0, 31'd16,
                                   31'd0};
        aresetn = 0;
        s_valid = 0;
        s_last_component = 0;
        {s_mean_left, s_mean_center, s_mean_right} = '0;
        {s_slope_left, s_slope_center, s_slope_right} = '0;
        cfg_wr_en = 0;
        cfg_index = wsl_pkg::REG_CELL_WIDTH;
        cfg_data = '0;
        sender_idles = 0;
        receiver_stalls = 0;
        idle_pct = 68;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 5 || ph == 7) begin
                ph_h[ph] = 31'($urandom_range(32'h7FFFFFFF, 1));
                ph_inv[ph] = 31'($urandom_range(32'h3FFFF, 1));
                ph_deg[ph] = 31'($urandom_range(16'hFFFF));
                ph_eps[ph] = 31'($urandom_range(65536, 1));
            end
            if (ph > 0) begin
                @(negedge aclk);
                s_valid <= 0;
                settle();
            end
            write_settings(ph_h[ph], ph_inv[ph], ph_deg[ph], ph_eps[ph]);
            sender_idles = (ph % 4 == 1) || (ph % 4 == 3);
            receiver_stalls = (ph % 4 == 2) || (ph % 4 == 3);
            idle_pct = (sender_idles && receiver_stalls) ? 29 : 68;
            if (ph == 0) begin
                send_component('0, '0, '0, '0, '0, '0, 0);
                send_component(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                               32'h7FFFFFFF, 32'h7FFFFFFF, 1);
                send_component(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                               32'h80000000, 32'h80000000, 0);
                send_component(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                               32'h80000000, 32'h7FFFFFFF, 1);
                send_component(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                               32'h7FFFFFFF, 32'h80000000, 0);
                send_component(32'h0, 32'h10000, 32'h20000, 32'h10000, 32'h10000,
                               32'h10000, 1);
                send_component(32'h10000, 32'h0, 32'h10000, 32'hFFFF0000, 32'h0,
                               32'h10000, 0);
                send_component(32'hFFFFFFFF, 32'h0, 32'h1, 32'h1, 32'hFFFFFFFF, 32'h0, 1);
                send_component(32'h12345678, 32'hEDCBA987, 32'h55555555, 32'hAAAAAAAA,
                               32'h0F0F0F0F, 32'hF0F0F0F0, 0);
                send_component(32'h0, 32'h0, 32'h0, 32'h3FFFFFFF, 32'h0, 32'hC0000000, 1);
            end
            repeat (180) send_random();
        end
        @(negedge aclk);
        s_valid <= 0;
        settle();
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// File: weno_slope_limiter.f
rtl/core/wsl_pkg.sv
rtl/core/weno_slope_limiter.sv
bench/wsl_checker.sv
bench/testbench.sv
